>>> rtl/gwd_pkg.sv
// Package for the grid interest window difference block.
// Holds the payload structs, the square descriptor, the scan states and shared constants.
// No dependencies.
`default_nettype none

package gwd_pkg;

	localparam int COORD_W = 6;
	localparam int SIDE_W = 7;
	localparam int RANGE_W = 2;
	localparam int ID_W = 12;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_GRID_SIDE = 64;
	localparam int MAX_SYNC_RANGE = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_RANGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

	typedef struct packed {
		logic               old_valid;
		logic [COORD_W-1:0] old_x;
		logic [COORD_W-1:0] old_z;
		logic               new_valid;
		logic [COORD_W-1:0] new_x;
		logic [COORD_W-1:0] new_z;
	} gwd_in_t;

	typedef struct packed {
		logic [ID_W-1:0] cell_id;
		logic            leaving;
		logic            last;
	} gwd_out_t;

	// Clamped interest square; bounds are inclusive.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] z0;
		logic [COORD_W-1:0] z1;
	} gwd_square_t;

	// Control handed from the top level to the scan sequencer.
	typedef struct packed {
		logic go;
		logic skip;
	} gwd_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN_OLD,
		ST_SCAN_NEW,
		ST_FLUSH
	} gwd_state_t;

endpackage

`default_nettype wire

>>> rtl/gwd_square.sv
// Builds the clamped interest square around one grid cell.
// Depends on gwd_pkg for the square type and widths.
`default_nettype none

module gwd_square (
	input  wire logic                         cell_valid,
	input  wire logic [gwd_pkg::COORD_W-1:0]  x,
	input  wire logic [gwd_pkg::COORD_W-1:0]  z,
	input  wire logic [gwd_pkg::RANGE_W-1:0]  range,
	input  wire logic [gwd_pkg::SIDE_W-1:0]   width,
	input  wire logic [gwd_pkg::SIDE_W-1:0]   height,
	output gwd_pkg::gwd_square_t              sq
);
	import gwd_pkg::*;

	logic [SIDE_W-1:0]  x_hi;
	logic [SIDE_W-1:0]  z_hi;
	logic [COORD_W-1:0] r_c;

	always_comb begin
		r_c  = COORD_W'(range);
		x_hi = {1'b0, x} + SIDE_W'(range);
		z_hi = {1'b0, z} + SIDE_W'(range);

		// A cell outside the configured grid has no square at all.
		sq.valid = cell_valid && ({1'b0, x} < width) && ({1'b0, z} < height);
		sq.x0    = (x < r_c) ? '0 : x - r_c;
		sq.z0    = (z < r_c) ? '0 : z - r_c;
		sq.x1    = (x_hi >= width) ? COORD_W'(width - SIDE_W'(1)) : x_hi[COORD_W-1:0];
		sq.z1    = (z_hi >= height) ? COORD_W'(height - SIDE_W'(1)) : z_hi[COORD_W-1:0];
	end

endmodule

`default_nettype wire

>>> rtl/gwd_scan.sv
// Scan sequencer: walks the old square then the new square one cell per cycle.
// A single shared compare and index unit tests membership and forms the cell id.
// Depends on gwd_pkg.
`default_nettype none

module gwd_scan (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  gwd_pkg::gwd_ctrl_t               ctrl,
	input  gwd_pkg::gwd_square_t             sq_old,
	input  gwd_pkg::gwd_square_t             sq_new,
	input  wire logic [gwd_pkg::SIDE_W-1:0]  width,
	output logic                             busy,
	output gwd_pkg::gwd_out_t                result,
	output logic                             result_strobe
);
	import gwd_pkg::*;

	gwd_state_t  state_q;
	gwd_state_t  state_d;
	gwd_square_t old_q;
	gwd_square_t new_q;
	gwd_square_t sq_a;
	gwd_square_t sq_b;

	logic [COORD_W-1:0]    x_q;
	logic [COORD_W-1:0]    z_q;
	logic [ID_W-1:0]       pend_id_q;
	logic                  pend_leaving_q;
	logic                  pend_valid_q;
	gwd_out_t              result_q;
	logic                  strobe_q;

	logic                  scanning;
	logic                  in_b;
	logic                  hit;
	logic                  col_end;
	logic                  at_end;
	logic                  emit;
	logic                  leaving_c;
	logic [ID_W-1:0]       id_c;
	logic [COORD_W+SIDE_W-1:0] prod_c;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.go && !ctrl.skip) begin
					state_d = sq_old.valid ? ST_SCAN_OLD : ST_SCAN_NEW;
				end
			end
			ST_SCAN_OLD: begin
				if (at_end) begin
					state_d = new_q.valid ? ST_SCAN_NEW : ST_FLUSH;
				end
			end
			ST_SCAN_NEW: begin
				if (at_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Shared compare and index unit plus control outputs.
	always_comb begin
		scanning  = (state_q == ST_SCAN_OLD) || (state_q == ST_SCAN_NEW);
		leaving_c = (state_q == ST_SCAN_OLD);
		sq_a      = (state_q == ST_SCAN_NEW) ? new_q : old_q;
		sq_b      = (state_q == ST_SCAN_NEW) ? old_q : new_q;

		in_b = sq_b.valid && (x_q >= sq_b.x0) && (x_q <= sq_b.x1)
			&& (z_q >= sq_b.z0) && (z_q <= sq_b.z1);
		hit     = scanning && !in_b;
		col_end = (x_q == sq_a.x1);
		at_end  = col_end && (z_q == sq_a.z1);

		prod_c = (COORD_W+SIDE_W)'(z_q) * (COORD_W+SIDE_W)'(width);
		id_c   = ID_W'(prod_c + (COORD_W+SIDE_W)'(x_q));

		// A held result goes out once the next one is found, or at the end with last set.
		emit = pend_valid_q && (hit || (state_q == ST_FLUSH));
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (state_q == ST_IDLE) begin
				pend_valid_q <= 1'b0;
			end else if (hit) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == ST_FLUSH) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (ctrl.go) begin
				old_q <= sq_old;
				new_q <= sq_new;
				x_q   <= sq_old.valid ? sq_old.x0 : sq_new.x0;
				z_q   <= sq_old.valid ? sq_old.z0 : sq_new.z0;
			end
		end else if (scanning) begin
			if (at_end) begin
				x_q <= new_q.x0;
				z_q <= new_q.z0;
			end else if (col_end) begin
				x_q <= sq_a.x0;
				z_q <= z_q + COORD_W'(1);
			end else begin
				x_q <= x_q + COORD_W'(1);
			end
		end
		if (hit) begin
			pend_id_q      <= id_c;
			pend_leaving_q <= leaving_c;
		end
		if (emit) begin
			result_q.cell_id <= pend_id_q;
			result_q.leaving <= pend_leaving_q;
			result_q.last    <= (state_q == ST_FLUSH);
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

>>> rtl/grid_interest_window_diff_top.sv
// Top level of the grid interest window difference block.
// Depends on gwd_pkg, gwd_square and gwd_scan.
`default_nettype none

// How to use this block:
// A transaction on the command channel is accepted at a rising edge where start is high
// and busy is low. The item names an old and a new grid cell, each with a valid flag.
// The block lists the cells of the old clamped square that are outside the new one
// (leaving set), then the cells of the new square outside the old one (leaving clear),
// in row order, left to right. Each result is shown for exactly one cycle with
// result_strobe high; the last result of an item has last set. An item whose cells are
// equal, or both invalid, yields no results and busy never rises for it.
// Timing: the sequencer visits one cell of a square per cycle through one shared
// compare and index unit, so an item keeps busy high while its squares are scanned
// and through the flush state that follows. Each result appears in the cycle after
// the next hit is found or after the flush state, and busy falls in the cycle that
// shows the last result, so a new item can be accepted then.
// The receiver cannot stall: results are never held back and must be taken as shown.
// Configuration transactions (sync_range, grid_width, grid_height) are always ready and
// must only be issued while the block is idle. Out-of-range values are clamped on use.
// Reset brings the registers to a range of one and a 64 by 64 grid, and the block idle.

module grid_interest_window_diff_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  gwd_pkg::gwd_in_t                    item,
	output logic                                busy,
	output gwd_pkg::gwd_out_t                   result,
	output logic                                result_strobe,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [gwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gwd_pkg::SIDE_W-1:0]     cfg_data
);
	import gwd_pkg::*;

	logic [RANGE_W-1:0] sync_range_q;
	logic [SIDE_W-1:0]  grid_width_q;
	logic [SIDE_W-1:0]  grid_height_q;

	logic [RANGE_W-1:0] range_c;
	logic [SIDE_W-1:0]  width_c;
	logic [SIDE_W-1:0]  height_c;

	gwd_square_t sq_old;
	gwd_square_t sq_new;
	gwd_ctrl_t   ctrl;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_range_q  <= RANGE_W'(1);
			grid_width_q  <= SIDE_W'(MAX_GRID_SIDE);
			grid_height_q <= SIDE_W'(MAX_GRID_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_RANGE:  sync_range_q  <= cfg_data[RANGE_W-1:0];
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Zero acts as one, and anything above the supported maximum acts as the maximum.
	always_comb begin
		if (sync_range_q == '0) begin
			range_c = RANGE_W'(1);
		end else if (sync_range_q > RANGE_W'(MAX_SYNC_RANGE)) begin
			range_c = RANGE_W'(MAX_SYNC_RANGE);
		end else begin
			range_c = sync_range_q;
		end

		if (grid_width_q == '0) begin
			width_c = SIDE_W'(1);
		end else if (grid_width_q > SIDE_W'(MAX_GRID_SIDE)) begin
			width_c = SIDE_W'(MAX_GRID_SIDE);
		end else begin
			width_c = grid_width_q;
		end

		if (grid_height_q == '0) begin
			height_c = SIDE_W'(1);
		end else if (grid_height_q > SIDE_W'(MAX_GRID_SIDE)) begin
			height_c = SIDE_W'(MAX_GRID_SIDE);
		end else begin
			height_c = grid_height_q;
		end
	end

	gwd_square u_sq_old (
		.cell_valid (item.old_valid),
		.x          (item.old_x),
		.z          (item.old_z),
		.range      (range_c),
		.width      (width_c),
		.height     (height_c),
		.sq         (sq_old)
	);

	gwd_square u_sq_new (
		.cell_valid (item.new_valid),
		.x          (item.new_x),
		.z          (item.new_z),
		.range      (range_c),
		.width      (width_c),
		.height     (height_c),
		.sq         (sq_new)
	);

	// An item produces nothing if neither cell is on the grid, or both name the same cell.
	always_comb begin
		ctrl.go   = start && !busy;
		ctrl.skip = (!sq_old.valid && !sq_new.valid)
			|| (sq_old.valid && sq_new.valid
				&& (item.old_x == item.new_x) && (item.old_z == item.new_z));
	end

	gwd_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.sq_old        (sq_old),
		.sq_new        (sq_new),
		.width         (width_c),
		.busy          (busy),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// Every result comes out of work done while the sequencer was busy.
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result shown without a preceding busy cycle");

	// The final result of an item is never directly followed by another result.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |=> !result_strobe)
		else $error("result directly after the last one");

	// Entering cells never precede leaving cells within an item.
	a_leaving_first: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.leaving) |=> !(result_strobe && result.leaving))
		else $error("leaving cell after an entering cell");

	// A freshly started scan has nothing to show in its first cycle.
	a_quiet_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !result_strobe)
		else $error("result shown as a scan starts");

endmodule

`default_nettype wire

>>> tb/tb_grid_interest_window_diff_top.sv
// Self-checking testbench for grid_interest_window_diff_top: directed and random cell moves,
// register settings at their extremes, and an in-bench window difference predictor.
// Depends on gwd_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_grid_interest_window_diff_top;
	import gwd_pkg::*;

	// Run limit in clock cycles.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles to let pass once nothing is expected. This covers an item that scans two
	// full squares without producing any result.
	localparam int SETTLE_CYCLES = 60;

	// Clamped interest square as the predictor sees it; bounds are inclusive.
	typedef struct {
		bit ok;
		int x0;
		int x1;
		int z0;
		int z1;
	} window_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	gwd_in_t               item;
	logic                  busy;
	gwd_out_t              result;
	logic                  result_strobe;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SIDE_W-1:0]     cfg_data;

	// Shadow copy of the configuration registers, updated on each write transaction.
	logic [RANGE_W-1:0]    cur_range;
	logic [SIDE_W-1:0]     cur_width;
	logic [SIDE_W-1:0]     cur_height;

	// Cells still to come from the block, oldest first.
	gwd_out_t              expected_cells[$];
	gwd_out_t              want;
	int                    failures;
	int                    cycles = 0;
	int                    sender_idle_pct;

	grid_interest_window_diff_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.item          (item),
		.busy          (busy),
		.result        (result),
		.result_strobe (result_strobe),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. A hung handshake or a result that never comes ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endfunction

	// Grid sides clamp to 1..MAX_GRID_SIDE and the range to 1..MAX_SYNC_RANGE on use.
	function automatic int eff_side(input logic [SIDE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_GRID_SIDE)
			return MAX_GRID_SIDE;
		return int'(v);
	endfunction

	function automatic int eff_range(input logic [RANGE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SYNC_RANGE)
			return MAX_SYNC_RANGE;
		return int'(v);
	endfunction

	// A cell outside the grid is treated like a missing one.
	function automatic window_t clamp_window(input bit v, input int x, input int z,
			input int r, input int w, input int h);
		window_t s;
		s.ok = v && x < w && z < h;
		s.x0 = (x - r < 0) ? 0 : x - r;
		s.z0 = (z - r < 0) ? 0 : z - r;
		s.x1 = (x + r >= w) ? w - 1 : x + r;
		s.z1 = (z + r >= h) ? h - 1 : z + r;
		return s;
	endfunction

	function automatic bit covers(input window_t s, input int x, input int z);
		return s.ok && x >= s.x0 && x <= s.x1 && z >= s.z0 && z <= s.z1;
	endfunction

	// Appends, in row order, every cell of a that b does not cover.
	function automatic void list_outside(input window_t a, input window_t b, input bit leaving,
			input int w, ref gwd_out_t found[$]);
		gwd_out_t entry;
		int id;
		if (!a.ok)
			return;
		for (int z = a.z0; z <= a.z1; z++) begin
			for (int x = a.x0; x <= a.x1; x++) begin
				if (!covers(b, x, z)) begin
					id = z * w + x;
					entry.cell_id = id[ID_W-1:0];
					entry.leaving = leaving;
					entry.last = 1'b0;
					found.push_back(entry);
				end
			end
		end
	endfunction

	// Queues the cells that one accepted move must produce under the current settings.
	function automatic void predict_window_diff(input gwd_in_t it);
		int w;
		int h;
		int r;
		window_t old_win;
		window_t new_win;
		gwd_out_t found[$];
		w = eff_side(cur_width);
		h = eff_side(cur_height);
		r = eff_range(cur_range);
		old_win = clamp_window(it.old_valid, int'(it.old_x), int'(it.old_z), r, w, h);
		new_win = clamp_window(it.new_valid, int'(it.new_x), int'(it.new_z), r, w, h);
		if (!old_win.ok && !new_win.ok)
			return;
		if (old_win.ok && new_win.ok && it.old_x == it.new_x && it.old_z == it.new_z)
			return;
		list_outside(old_win, new_win, 1'b1, w, found);
		list_outside(new_win, old_win, 1'b0, w, found);
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i])
			expected_cells.push_back(found[i]);
	endfunction

	// Result checker. The receiver cannot stall, so every strobe is one transaction.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (expected_cells.size() == 0) begin
				note_failure($sformatf("unexpected result: cell_id %0d leaving %0b last %0b",
					result.cell_id, result.leaving, result.last));
			end else begin
				want = expected_cells.pop_front();
				if (result.cell_id !== want.cell_id || result.leaving !== want.leaving ||
						result.last !== want.last)
					note_failure($sformatf(
						"result mismatch: expected id %0d lv %0b last %0b, got id %0d lv %0b last %0b",
						want.cell_id, want.leaving, want.last,
						result.cell_id, result.leaving, result.last));
			end
		end
	end

	// Sends one move. Start stays high from one transaction to the next unless the sender
	// idles, so it never gets two assignments in one time step.
	task automatic send_move(input gwd_in_t it);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(($urandom_range(9) == 0) ? 55 : 6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_window_diff(it);
	endtask

	task automatic send_fields(input bit ov, input int ox, input int oz,
			input bit nv, input int nx, input int nz);
		gwd_in_t it;
		it.old_valid = ov;
		it.old_x = ox[COORD_W-1:0];
		it.old_z = oz[COORD_W-1:0];
		it.new_valid = nv;
		it.new_x = nx[COORD_W-1:0];
		it.new_z = nz[COORD_W-1:0];
		send_move(it);
	endtask

	// Stops sending and waits until every expected cell is back and the block is idle. The
	// settle time covers a move that keeps the block scanning without producing a result.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high for the caller, which lowers it after the last write.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SYNC_RANGE: begin
				cur_range = val[RANGE_W-1:0];
			end
			CFG_GRID_WIDTH: begin
				cur_width = val;
			end
			CFG_GRID_HEIGHT: begin
				cur_height = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic apply_config(input int r, input int w, input int h);
		drain_results();
		write_register(CFG_SYNC_RANGE, r[SIDE_W-1:0]);
		write_register(CFG_GRID_WIDTH, w[SIDE_W-1:0]);
		write_register(CFG_GRID_HEIGHT, h[SIDE_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed moves to a nearby cell inside the grid, some that enter or leave,
	// some landing just past the grid edge, and a share of raw noise over all field bits.
	function automatic gwd_in_t random_move();
		gwd_in_t it;
		logic [31:0] raw;
		int w;
		int h;
		int kind;
		int nx;
		int nz;
		w = eff_side(cur_width);
		h = eff_side(cur_height);
		kind = $urandom_range(99);
		raw = $urandom;
		it = raw[$bits(gwd_in_t)-1:0];
		if (kind < 20)
			return it;
		it.old_valid = 1'b1;
		it.new_valid = 1'b1;
		if (kind < 30) begin
			it.old_x = COORD_W'($urandom_range((w + 1 > 63) ? 63 : w + 1));
			it.old_z = COORD_W'($urandom_range((h + 1 > 63) ? 63 : h + 1));
		end else begin
			it.old_x = COORD_W'($urandom_range(w - 1));
			it.old_z = COORD_W'($urandom_range(h - 1));
		end
		nx = int'(it.old_x) + int'($urandom_range(6)) - 3;
		nz = int'(it.old_z) + int'($urandom_range(6)) - 3;
		it.new_x = (nx < 0) ? '0 : (nx > 63) ? COORD_W'(63) : nx[COORD_W-1:0];
		it.new_z = (nz < 0) ? '0 : (nz > 63) ? COORD_W'(63) : nz[COORD_W-1:0];
		if (kind >= 90) begin
			if (kind[0])
				it.old_valid = 1'b0;
			else
				it.new_valid = 1'b0;
		end
		return it;
	endfunction

	// Reset settings: range one on a 64 by 64 grid. Covers the grid corners, entering,
	// leaving, both cells missing, no move at all, and overlapping, touching and
	// disjoint squares.
	task automatic test_reset_settings();
		send_fields(1, 0, 0, 1, 63, 63);
		send_fields(0, 0, 0, 1, 0, 0);
		send_fields(1, 63, 63, 0, 63, 63);
		send_fields(0, 5, 5, 0, 9, 9);
		send_fields(1, 20, 20, 1, 20, 20);
		send_fields(1, 10, 10, 1, 11, 10);
		send_fields(1, 10, 10, 1, 13, 10);
		send_fields(1, 10, 10, 1, 12, 12);
		send_fields(1, 63, 0, 1, 0, 63);
	endtask

	// Coordinates past the grid edge make a cell count as missing.
	task automatic test_beyond_grid();
		apply_config(1, 20, 20);
		send_fields(1, 25, 5, 1, 5, 5);
		send_fields(1, 5, 5, 1, 5, 20);
		send_fields(1, 19, 19, 1, 18, 19);
		send_fields(1, 30, 30, 1, 30, 30);
	endtask

	// Register values outside their legal range are clamped when used. The last setting
	// gives a one column grid where two different cells share the same square.
	task automatic test_register_clamps();
		apply_config(0, 0, 127);
		send_fields(1, 0, 0, 1, 0, 5);
		send_fields(1, 0, 63, 0, 0, 0);
		send_fields(1, 1, 1, 1, 0, 2);
		apply_config(3, 127, 0);
		send_fields(1, 0, 0, 1, 63, 0);
		send_fields(1, 30, 0, 1, 32, 0);
		send_fields(0, 0, 0, 1, 31, 0);
		apply_config(2, 1, 3);
		send_fields(1, 0, 0, 1, 0, 1);
		send_fields(1, 0, 0, 1, 0, 2);
		send_fields(0, 0, 0, 1, 0, 1);
	endtask

	// Largest squares: two disjoint full 5 by 5 windows give the longest result list.
	task automatic test_largest_windows();
		apply_config(2, 64, 64);
		send_fields(1, 2, 2, 1, 61, 61);
		send_fields(1, 31, 31, 1, 32, 33);
	endtask

	// Random moves under one setting. With pause_mid set, the sender stops halfway and
	// waits until every expected cell has come back.
	task automatic test_random_moves(input int idle_pct, input int r, input int w, input int h,
			input int count, input bit pause_mid);
		apply_config(r, w, h);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			if (pause_mid && n == count / 2)
				drain_results();
			send_move(random_move());
		end
	endtask

	initial begin
		gwd_out_t left_over;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SYNC_RANGE;
		cfg_data = '0;
		cur_range = 2'd1;
		cur_width = 7'd64;
		cur_height = 7'd64;
		failures = 0;
		sender_idle_pct = 35;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_beyond_grid();
		test_register_clamps();
		test_largest_windows();
		test_random_moves(35, 2, 64, 64, 60, 1'b0);
		test_random_moves(79, 1, 13, 7, 50, 1'b1);
		test_random_moves(0, 3, 127, 127, 50, 1'b0);
		test_random_moves(0, $urandom_range(3), $urandom_range(127), $urandom_range(127), 40,
			1'b0);

		drain_results();
		while (expected_cells.size() != 0) begin
			left_over = expected_cells.pop_front();
			note_failure($sformatf("missing result: cell_id %0d leaving %0b last %0b",
				left_over.cell_id, left_over.leaving, left_over.last));
		end
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/gwd_pkg.sv
rtl/gwd_square.sv
rtl/gwd_scan.sv
rtl/grid_interest_window_diff_top.sv
tb/tb_grid_interest_window_diff_top.sv
